// ----- hw/rtl/tgre_pkg.sv -----
// Shared types and constants of the tile grid edge run extractor.
// Holds the segment record, the controller command and status structs.
// No dependencies.
package tgre_pkg;

   localparam int X_W       = 5;
   localparam int Y_W       = 12;
   localparam int LVL_W     = 8;
   localparam int NUM_SLOTS = 12;
   localparam int SLOT_W    = 4;
   localparam int TDATA_W   = 48;

   // Register select is address bit 2.
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [X_W-1:0]          sx;
      logic [Y_W-1:0]          sy;
      logic [X_W-1:0]          ex;
      logic [Y_W-1:0]          ey;
      logic signed [LVL_W-1:0] lvl;
   } seg_type;

   typedef struct packed {
      logic capture;
      logic phase_a;
      logic phase_b;
      logic pop;
      logic restart;
   } cmd_type;

   typedef struct packed {
      logic any;
      logic last;
   } stat_type;

   function automatic seg_type mk_seg(logic [X_W-1:0] sx, logic [Y_W-1:0] sy,
                                      logic [X_W-1:0] ex, logic [Y_W-1:0] ey,
                                      logic signed [LVL_W-1:0] lvl);
      seg_type s;
      s.sx  = sx;
      s.sy  = sy;
      s.ex  = ex;
      s.ey  = ey;
      s.lvl = lvl;
      return s;
   endfunction

endpackage

// ----- hw/rtl/tgre_ctrl.sv -----
// Sequencer of the tile grid edge run extractor.
// Depends on tgre_pkg for the command and status structs.
module tgre_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               cfg_write,
   input  tgre_pkg::stat_type stat,
   output tgre_pkg::cmd_type  cmd
);
   import tgre_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_PH_A, S_PH_B, S_EMIT} state_type;

   state_type state_ff;

   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      rsp_tvalid  = (state_ff == S_EMIT) && stat.any;
      cmd.capture = req_tready && req_tvalid;
      cmd.phase_a = (state_ff == S_PH_A);
      cmd.phase_b = (state_ff == S_PH_B);
      cmd.pop     = rsp_tvalid && rsp_tready;
      cmd.restart = cfg_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_PH_A;
            end
            S_PH_A: state_ff <= S_PH_B;
            S_PH_B: state_ff <= S_EMIT;
            S_EMIT: begin
               if (!stat.any || (rsp_tready && stat.last)) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/tgre_datapath.sv -----
// Datapath of the tile grid edge run extractor: run state, row and column
// stores, and the per-tile segment slots. Depends on tgre_pkg.
module tgre_datapath #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tgre_pkg::cmd_type             cmd,
   output tgre_pkg::stat_type            stat,
   input  logic [tgre_pkg::X_W-1:0]      cfg_width,
   input  logic [tgre_pkg::Y_W-1:0]      cfg_height,
   input  logic signed [tgre_pkg::LVL_W-1:0] req_level,
   output tgre_pkg::seg_type             seg
);
   import tgre_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic signed [LVL_W-1:0] level_ff, left_ff, above_ff, old_ff, rsl_ff;
   logic signed [LVL_W-1:0] prv_ff [MAX_WIDTH];
   logic [Y_W-1:0]          crs_ff [MAX_WIDTH+1];
   logic [Y_W-1:0]          css_ff [MAX_WIDTH+1];
   logic [MAX_WIDTH:0]      cso_ff, cvld_ff;
   logic [CW-1:0]           rrs_ff, rss_ff, col_ff;
   logic                    rso_ff;
   logic [Y_W-1:0]          row_ff, y_ff;
   logic                    lrow_ff, rend_ff;
   seg_type                 seg_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]    mask_ff;

   // Effective geometry.
   logic [CW-1:0]  ew;
   logic [Y_W-1:0] eh;

   always_comb begin
      if (cfg_width == '0) ew = CW'(1);
      else if (cfg_width > X_W'(MAX_WIDTH)) ew = CW'(MAX_WIDTH);
      else ew = cfg_width[CW-1:0];
      eh = (cfg_height == '0) ? Y_W'(1) : cfg_height;
   end

   // Phase A: everything of the tile except the right boundary line.
   logic                    a_rs, a_lrow, a_rend, a_hclose, a_cv;
   logic [CW-1:0]           a_x, a_rrs, a_rrs1, a_rss, a_rss1;
   logic [Y_W-1:0]          a_y, a_crs, a_crs1, a_css, a_css1;
   logic                    a_rso, a_rso1, a_cso, a_cso1, a_pres, a_pres2, a_cl;
   logic signed [LVL_W-1:0] a_old, a_left, a_al, a_rsl, a_rsl1;
   logic [9:0]              a_vld;
   logic [MAX_WIDTH:0]      a_cvld;
   seg_type                 a_seg [10];

   always_comb begin
      a_rs   = (col_ff >= ew) || (row_ff >= eh);
      a_x    = a_rs ? '0 : col_ff;
      a_y    = a_rs ? '0 : row_ff;
      a_rrs  = a_rs ? '0 : rrs_ff;
      a_rso  = a_rs ? 1'b0 : rso_ff;
      a_rss  = a_rs ? '0 : rss_ff;
      a_rsl  = a_rs ? '0 : rsl_ff;
      a_al   = a_rs ? '0 : above_ff;
      a_cv   = !a_rs && cvld_ff[a_x];
      a_crs  = a_cv ? crs_ff[a_x] : '0;
      a_cso  = a_cv && cso_ff[a_x];
      a_css  = a_cv ? css_ff[a_x] : '0;
      a_old  = prv_ff[a_x[XW-1:0]];
      a_left = (a_x != '0) ? left_ff : '0;
      a_lrow = (a_y == eh - 1'b1);
      a_rend = (a_x == ew - 1'b1);
      a_vld  = '0;
      for (int i = 0; i < 10; i++) a_seg[i] = '0;

      // A restarted grid forgets every column entry but the one written now.
      a_cvld       = a_rs ? '0 : cvld_ff;
      a_cvld[a_x]  = 1'b1;

      // Tile-edge run on the row line.
      a_hclose = (a_x != '0) && (level_ff != a_left);
      a_vld[0] = a_hclose;
      a_seg[0] = mk_seg(X_W'(a_rrs), a_y, X_W'(a_x), a_y, a_left);
      if (a_x == '0) a_rrs1 = '0;
      else if (a_hclose) a_rrs1 = a_x;
      else a_rrs1 = a_rrs;

      // Step run on the row line.
      a_pres = (a_old != level_ff);
      a_cl   = (a_y != '0) && a_rso && (!a_pres || a_old != a_rsl);
      a_vld[1] = a_cl;
      a_seg[1] = mk_seg(X_W'(a_rss), a_y, X_W'(a_x), a_y, a_rsl);
      a_rso1 = a_rso && !a_cl;
      a_rss1 = a_rss;
      a_rsl1 = a_rsl;
      if ((a_y != '0) && a_pres && !a_rso1) begin
         a_rso1 = 1'b1;
         a_rss1 = a_x;
         a_rsl1 = a_old;
      end

      // Bottom boundary, row end closures.
      a_vld[2] = a_hclose && a_lrow;
      a_seg[2] = mk_seg(X_W'(a_rrs), eh, X_W'(a_x), eh, a_left);
      a_vld[3] = a_rend;
      a_seg[3] = mk_seg(X_W'(a_rrs1), a_y, X_W'(ew), a_y, level_ff);
      a_vld[4] = a_rend && a_rso1;
      a_seg[4] = mk_seg(X_W'(a_rss1), a_y, X_W'(ew), a_y, a_rsl1);
      if (a_rend) a_rso1 = 1'b0;
      a_vld[5] = a_rend && a_lrow;
      a_seg[5] = mk_seg(X_W'(a_rrs1), eh, X_W'(ew), eh, level_ff);

      // Tile-edge run on the column line.
      a_vld[6] = (a_y != '0) && (level_ff != a_old);
      a_seg[6] = mk_seg(X_W'(a_x), a_crs, X_W'(a_x), a_y, a_old);
      if (a_y == '0) a_crs1 = '0;
      else if (level_ff != a_old) a_crs1 = a_y;
      else a_crs1 = a_crs;
      a_vld[7] = a_lrow;
      a_seg[7] = mk_seg(X_W'(a_x), a_crs1, X_W'(a_x), eh, level_ff);

      // Step run on the column line.
      a_pres2 = (a_left != level_ff);
      a_cso1  = a_cso;
      a_css1  = a_css;
      if (a_x != '0) begin
         a_vld[8] = a_cso && (!a_pres2 || a_left != a_al);
         a_seg[8] = mk_seg(X_W'(a_x), a_css, X_W'(a_x), a_y, a_al);
         if (a_vld[8]) a_cso1 = 1'b0;
         if (a_pres2 && !a_cso1) begin
            a_cso1 = 1'b1;
            a_css1 = a_y;
         end
         a_vld[9] = a_lrow && a_cso1;
         a_seg[9] = mk_seg(X_W'(a_x), a_css1, X_W'(a_x), eh, a_left);
         if (a_lrow) a_cso1 = 1'b0;
      end
   end

   // Phase B: right boundary line, entry ew of the column store.
   logic           b_wv, b_co, b_co1, b_cl;
   logic [Y_W-1:0] b_cs, b_cs1;
   logic [1:0]     b_vld;
   seg_type        b_seg [2];

   always_comb begin
      b_wv  = cvld_ff[ew];
      b_co  = b_wv && cso_ff[ew];
      b_cs  = b_wv ? css_ff[ew] : '0;
      b_cl  = b_co && (level_ff != old_ff);
      b_co1 = b_co && !b_cl;
      b_cs1 = b_cs;
      if (!b_co1) begin
         b_co1 = 1'b1;
         b_cs1 = y_ff;
      end
      b_vld[0] = rend_ff && b_cl;
      b_seg[0] = mk_seg(X_W'(ew), b_cs, X_W'(ew), y_ff, old_ff);
      b_vld[1] = rend_ff && lrow_ff;
      b_seg[1] = mk_seg(X_W'(ew), b_cs1, X_W'(ew), eh, level_ff);
      if (lrow_ff) b_co1 = 1'b0;
   end

   // Lowest pending slot goes out first.
   logic [SLOT_W-1:0] sel;

   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = SLOT_W'(i);
      end
      seg       = seg_ff[sel];
      stat.any  = (mask_ff != '0);
      stat.last = ((mask_ff & (mask_ff - 1'b1)) == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) level_ff <= req_level;
      if (cmd.phase_a) begin
         for (int i = 0; i < 10; i++) seg_ff[i] <= a_seg[i];
         crs_ff[a_x] <= a_crs1;
         css_ff[a_x] <= a_css1;
         rrs_ff      <= a_rrs1;
         rss_ff      <= a_rss1;
         rsl_ff      <= a_rsl1;
         left_ff     <= level_ff;
         old_ff      <= a_old;
         y_ff        <= a_y;
         lrow_ff     <= a_lrow;
         rend_ff     <= a_rend;
      end
      if (cmd.phase_b) begin
         seg_ff[10] <= b_seg[0];
         seg_ff[11] <= b_seg[1];
         if (rend_ff) css_ff[ew] <= b_cs1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) prv_ff[i] <= '0;
         cvld_ff  <= '0;
         cso_ff   <= '0;
         rso_ff   <= 1'b0;
         above_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         mask_ff  <= '0;
      end else if (cmd.restart) begin
         cvld_ff  <= '0;
         rso_ff   <= 1'b0;
         above_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (cmd.phase_a) begin
         cvld_ff               <= a_cvld;
         cso_ff[a_x]           <= a_cso1;
         prv_ff[a_x[XW-1:0]]   <= level_ff;
         rso_ff                <= a_rso1;
         above_ff              <= a_old;
         mask_ff               <= {2'b00, a_vld};
         col_ff                <= a_rend ? '0 : a_x + 1'b1;
         row_ff                <= a_rend ? (a_lrow ? '0 : a_y + 1'b1) : a_y;
      end else if (cmd.phase_b) begin
         mask_ff[NUM_SLOTS-1:NUM_SLOTS-2] <= b_vld;
         if (rend_ff && lrow_ff) begin
            // Grid complete: drop every open run for the next grid.
            cvld_ff  <= '0;
            rso_ff   <= 1'b0;
            above_ff <= '0;
         end else if (rend_ff) begin
            cvld_ff[ew] <= 1'b1;
            cso_ff[ew]  <= b_co1;
         end
      end else if (cmd.pop) begin
         mask_ff <= mask_ff & (mask_ff - 1'b1);
      end
   end

endmodule

// ----- hw/rtl/tile_grid_edge_run_extractor.sv -----
// Top level of the tile grid edge run extractor: configuration registers,
// stream ports, and the controller and datapath. Depends on tgre_pkg,
// tgre_ctrl and tgre_datapath.
//
// Usage: tile levels enter on the req_ stream in row-major order, one
// transaction per tile. For each tile the block produces zero or more
// outline segments on the rsp_ stream; tlast marks the final segment
// caused by that tile. Horizontal segments come before vertical ones.
// Flow: a tile is accepted, then phase A computes all its segments but those
// on the right boundary line, and phase B those on the right boundary line,
// since the column store has a single access port. Segments then leave at one
// per cycle while the receiver is ready. The next tile is accepted only once
// every segment of the current tile has been taken.
// When the receiver stalls, the current segment holds on rsp_ and no new
// tile is taken. Reset clears all runs and the row store, sets grid_width
// to 16 and grid_height to 1. A register write restarts the grid at tile
// 0,0 and drops all open runs; write only while the block is idle.
module tile_grid_edge_run_extractor #(
   parameter int MAX_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: tile_level [7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // tdata: start_x [4:0], start_y [16:5], end_x [21:17], end_y [33:22],
   //        level [41:34], zero fill [47:42]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tgre_pkg::*;

   logic [X_W-1:0] width_ff;
   logic [Y_W-1:0] height_ff;
   logic           cfg_write;
   cmd_type        cmd;
   stat_type       stat;
   seg_type        seg;

   // Register write completes in the access cycle.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= X_W'(16);
         height_ff <= Y_W'(1);
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_GRID_WIDTH:  width_ff  <= csr_pwdata[X_W-1:0];
            REG_GRID_HEIGHT: height_ff <= csr_pwdata[Y_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GRID_WIDTH:  csr_prdata = {{(32-X_W){1'b0}}, width_ff};
         REG_GRID_HEIGHT: csr_prdata = {{(32-Y_W){1'b0}}, height_ff};
         default:         csr_prdata = '0;
      endcase
   end

   tgre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cfg_write  (cfg_write),
      .stat       (stat),
      .cmd        (cmd)
   );

   tgre_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .req_level  (req_tdata),
      .seg        (seg)
   );

   // The segment shown is held in the slot registers until it is taken.
   assign rsp_tdata = {6'b0, seg.lvl, seg.ey, seg.ex, seg.sy, seg.sx};
   assign rsp_tlast = stat.last;

endmodule
